// ===== src/okp_pkg.sv =====
// ---------------------------------------------------------------------------
// okp_pkg - shared types and constants of the optical key press detector
// Sizes, register codes, controller states and controller command/status.
// ---------------------------------------------------------------------------
`default_nettype none

package okp_pkg;

  // number of sensor slots in the baseline store
  localparam int MAX_SENSORS = 72;

  localparam int ADDR_W  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int COUNT_W = $clog2(MAX_SENSORS + 1);

  // field widths fixed by the interface
  localparam int SAMPLE_W   = 16;
  localparam int SENSOR_W   = 7;
  localparam int TRAVEL_W   = 16;
  localparam int VCOUNT_W   = 7;
  localparam int SETTLE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // baseline is 12 bits, stored together with the pressed bit
  localparam int BASE_W  = 12;
  localparam int ENTRY_W = BASE_W + 1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h0fff;

  // one quotient bit per divider step
  localparam int DIV_STEPS = TRAVEL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // reset values of the registers
  localparam logic [SENSOR_W-1:0] RST_SENSOR_COUNT = 7'd72;
  localparam logic [TRAVEL_W-1:0] RST_PRESS_THR    = 16'd32768;
  localparam logic [TRAVEL_W-1:0] RST_RELEASE_THR  = 16'd16384;
  localparam logic [SETTLE_W-1:0] RST_SETTLE_TGT   = 8'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_COUNT = 2'd0,
    CFG_PRESS_THR    = 2'd1,
    CFG_RELEASE_THR  = 2'd2,
    CFG_SETTLE_TGT   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming sample and its slot
    logic lookup;    // baseline read data is valid, update and load divider
    logic div_step;  // one restoring division step
    logic finish;    // write back, update frame state, load result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_div;    // travel needs the division
    logic last_step;  // this is the final division step
    logic out_free;   // result register can take a new beat
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== src/okp_if.sv =====
// ---------------------------------------------------------------------------
// okp_if - handshake channels of the optical key press detector
// Sample input, result output and register write channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface okp_in_if;
  logic                          valid;
  logic                          ready;
  logic [okp_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface okp_out_if;
  logic                          valid;
  logic                          ready;
  logic [okp_pkg::SENSOR_W-1:0]  sensor;
  logic                          valid_res;
  logic [okp_pkg::TRAVEL_W-1:0]  travel;
  logic                          pressed;
  logic                          changed;
  logic                          frame_end;
  logic [okp_pkg::VCOUNT_W-1:0]  frame_valid_count;
  logic                          settled;

  modport source (output valid, output sensor, output valid_res, output travel,
                  output pressed, output changed, output frame_end,
                  output frame_valid_count, output settled, input ready);
  modport sink   (input valid, input sensor, input valid_res, input travel,
                  input pressed, input changed, input frame_end,
                  input frame_valid_count, input settled, output ready);
endinterface

interface okp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [okp_pkg::CFG_IDX_W-1:0]  index;
  logic [okp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/okp_ram.sv =====
// ---------------------------------------------------------------------------
// okp_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, no reset on contents.
// ---------------------------------------------------------------------------
`default_nettype none

module okp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output      logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/okp_ctrl.sv =====
// ---------------------------------------------------------------------------
// okp_ctrl - sequencer of the optical key press detector
// Walks one sample through lookup, optional division and write-back.
// ---------------------------------------------------------------------------
`default_nettype none

module okp_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire okp_pkg::ctrl_sts_t sts_i,
  output      okp_pkg::ctrl_cmd_t cmd_o
);

  okp_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= okp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      okp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = okp_pkg::ST_LOOKUP;
      end
      okp_pkg::ST_LOOKUP: begin
        state_d = sts_i.run_div ? okp_pkg::ST_DIVIDE : okp_pkg::ST_FINISH;
      end
      okp_pkg::ST_DIVIDE: begin
        if (sts_i.last_step) state_d = okp_pkg::ST_FINISH;
      end
      okp_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = okp_pkg::ST_IDLE;
      end
      default: state_d = okp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      okp_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      okp_pkg::ST_LOOKUP: cmd_o.lookup   = 1'b1;
      okp_pkg::ST_DIVIDE: cmd_o.div_step = 1'b1;
      okp_pkg::ST_FINISH: cmd_o.finish   = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/okp_datapath.sv =====
// ---------------------------------------------------------------------------
// okp_datapath - baseline store, travel divider and frame bookkeeping
// Holds the registers, per-sensor state, restoring divider and result beat.
// ---------------------------------------------------------------------------
`default_nettype none

module okp_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [okp_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire okp_pkg::ctrl_cmd_t            cmd_i,
  output      okp_pkg::ctrl_sts_t            sts_o,
  okp_cfg_if.sink                            cfg_i,
  okp_out_if.source                          out_o
);

  localparam int AW = okp_pkg::ADDR_W;
  localparam int CW = okp_pkg::COUNT_W;
  localparam int BW = okp_pkg::BASE_W;

  // configuration registers
  logic [okp_pkg::SENSOR_W-1:0] sensor_count_q;
  logic [okp_pkg::TRAVEL_W-1:0] press_thr_q;
  logic [okp_pkg::TRAVEL_W-1:0] release_thr_q;
  logic [okp_pkg::SETTLE_W-1:0] settle_tgt_q;

  // frame state
  logic [AW-1:0]                frame_pos_q;
  logic [CW-1:0]                valid_cnt_q;
  logic [okp_pkg::SETTLE_W-1:0] settle_cnt_q;
  logic [okp_pkg::MAX_SENSORS-1:0] entry_vld_q;

  // per-item registers
  logic [okp_pkg::SAMPLE_W-1:0] sample_q;
  logic [AW-1:0]                addr_q;
  logic                         valid_q;
  logic [BW-1:0]                base_q;
  logic                         pr_q;
  logic                         run_div_q;
  logic [BW-1:0]                rem_q;
  logic [okp_pkg::TRAVEL_W-1:0] quot_q;
  logic [okp_pkg::DIV_CNT_W-1:0] div_cnt_q;

  // result beat
  logic                         out_vld_q;
  logic [okp_pkg::SENSOR_W-1:0] res_sensor_q;
  logic                         res_valid_q;
  logic [okp_pkg::TRAVEL_W-1:0] res_travel_q;
  logic                         res_pressed_q;
  logic                         res_changed_q;
  logic                         res_last_q;
  logic [okp_pkg::VCOUNT_W-1:0] res_vcount_q;
  logic                         res_settled_q;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_count_q <= okp_pkg::RST_SENSOR_COUNT;
      press_thr_q    <= okp_pkg::RST_PRESS_THR;
      release_thr_q  <= okp_pkg::RST_RELEASE_THR;
      settle_tgt_q   <= okp_pkg::RST_SETTLE_TGT;
    end else if (cfg_i.valid) begin
      unique case (okp_pkg::cfg_reg_e'(cfg_i.index))
        okp_pkg::CFG_SENSOR_COUNT: sensor_count_q <= cfg_i.data[okp_pkg::SENSOR_W-1:0];
        okp_pkg::CFG_PRESS_THR:    press_thr_q    <= cfg_i.data[okp_pkg::TRAVEL_W-1:0];
        okp_pkg::CFG_RELEASE_THR:  release_thr_q  <= cfg_i.data[okp_pkg::TRAVEL_W-1:0];
        okp_pkg::CFG_SETTLE_TGT:   settle_tgt_q   <= cfg_i.data[okp_pkg::SETTLE_W-1:0];
      endcase
    end
  end

  // active sensor count: zero acts as one, clipped to the store depth
  logic [CW-1:0] active_n;
  always_comb begin
    priority if (sensor_count_q == '0) begin
      active_n = CW'(1);
    end else if (int'(sensor_count_q) > okp_pkg::MAX_SENSORS) begin
      active_n = CW'(okp_pkg::MAX_SENSORS);
    end else begin
      active_n = CW'(sensor_count_q);
    end
  end

  // current slot, clipped to the last sensor
  logic [AW-1:0] cur_pos;
  assign cur_pos = (int'(frame_pos_q) >= okp_pkg::MAX_SENSORS) ?
                   AW'(okp_pkg::MAX_SENSORS - 1) : frame_pos_q;

  logic settled;
  assign settled = settle_cnt_q >= settle_tgt_q;

  // per-sensor store: {pressed, baseline}
  logic                        ram_we;
  logic [okp_pkg::ENTRY_W-1:0] ram_wdata;
  logic [okp_pkg::ENTRY_W-1:0] ram_rdata;

  okp_ram #(
    .WIDTH (okp_pkg::ENTRY_W),
    .DEPTH (okp_pkg::MAX_SENSORS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (cur_pos),
    .rdata_o (ram_rdata)
  );

  // lookup: an entry never written reads as zero
  logic [okp_pkg::ENTRY_W-1:0] entry;
  logic [BW-1:0]               base_old;
  logic [BW-1:0]               s12;
  logic                        take_sample;
  logic [BW-1:0]               base_new;
  logic                        run_div;

  assign entry       = entry_vld_q[addr_q] ? ram_rdata : '0;
  assign base_old    = entry[BW-1:0];
  assign s12         = sample_q[BW-1:0];
  assign take_sample = (settle_cnt_q == '0) || (base_old == '0) || (s12 > base_old);
  assign base_new    = take_sample ? s12 : base_old;
  assign run_div     = valid_q && settled && (base_new >= BW'(2)) && (s12 < base_new);

  // restoring division step
  logic [BW:0] rem_shl;
  logic        rem_ge;
  assign rem_shl = {rem_q, 1'b0};
  assign rem_ge  = rem_shl >= {1'b0, base_q};

  // finish: hysteresis and frame bookkeeping
  logic [okp_pkg::TRAVEL_W-1:0] travel;
  logic                         pr_next;
  logic                         pr_new;
  logic                         chg;
  logic [CW-1:0]                vcount_new;
  logic                         last;

  // quotient stays below 2^16 because baseline - sample < baseline
  assign travel     = run_div_q ? quot_q : '0;
  assign pr_next    = pr_q ? (travel >= release_thr_q) : (travel >= press_thr_q);
  assign chg        = valid_q && settled && (pr_next != pr_q);
  assign pr_new     = chg ? pr_next : pr_q;
  assign vcount_new = valid_cnt_q + CW'(valid_q);
  assign last       = (CW'(addr_q) + CW'(1)) >= active_n;

  assign ram_we    = cmd_i.finish && valid_q;
  assign ram_wdata = {pr_new, base_q};

  // status to the controller
  assign sts_o.run_div   = run_div;
  assign sts_o.last_step = div_cnt_q == okp_pkg::DIV_CNT_W'(1);
  assign sts_o.out_free  = !out_vld_q || out_o.ready;

  // item payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
      addr_q   <= cur_pos;
      valid_q  <= (sample_i != '0) && (sample_i <= okp_pkg::SAMPLE_MAX);
    end
    if (cmd_i.lookup) begin
      base_q    <= base_new;
      pr_q      <= entry[BW];
      run_div_q <= run_div;
      rem_q     <= base_new - s12;
      quot_q    <= '0;
      div_cnt_q <= okp_pkg::DIV_CNT_W'(okp_pkg::DIV_STEPS);
    end else if (cmd_i.div_step) begin
      rem_q     <= rem_ge ? BW'(rem_shl - {1'b0, base_q}) : rem_shl[BW-1:0];
      quot_q    <= {quot_q[okp_pkg::TRAVEL_W-2:0], rem_ge};
      div_cnt_q <= div_cnt_q - okp_pkg::DIV_CNT_W'(1);
    end
  end

  // frame state and store valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos_q  <= '0;
      valid_cnt_q  <= '0;
      settle_cnt_q <= '0;
      entry_vld_q  <= '0;
    end else if (cmd_i.finish) begin
      if (valid_q) entry_vld_q[addr_q] <= 1'b1;
      if (last) begin
        if (vcount_new == active_n && settle_cnt_q < settle_tgt_q) begin
          settle_cnt_q <= settle_cnt_q + okp_pkg::SETTLE_W'(1);
        end
        frame_pos_q <= '0;
        valid_cnt_q <= '0;
      end else begin
        frame_pos_q <= addr_q + AW'(1);
        valid_cnt_q <= vcount_new;
      end
    end
  end

  // result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_sensor_q  <= okp_pkg::SENSOR_W'(addr_q);
      res_valid_q   <= valid_q;
      res_travel_q  <= travel;
      res_pressed_q <= pr_new;
      res_changed_q <= chg;
      res_last_q    <= last;
      res_vcount_q  <= okp_pkg::VCOUNT_W'(vcount_new);
      res_settled_q <= settled;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.sensor            = res_sensor_q;
  assign out_o.valid_res         = res_valid_q;
  assign out_o.travel            = res_travel_q;
  assign out_o.pressed           = res_pressed_q;
  assign out_o.changed           = res_changed_q;
  assign out_o.frame_end         = res_last_q;
  assign out_o.frame_valid_count = res_vcount_q;
  assign out_o.settled           = res_settled_q;

endmodule

`default_nettype wire

// ===== src/optical_key_press_detector.sv =====
// ---------------------------------------------------------------------------
// optical_key_press_detector - analog key travel detector with hysteresis
// Per-sensor baseline tracking, Q16 travel and pressed/released decision.
// ---------------------------------------------------------------------------
// One sample is taken at a time, in sensor order within a frame, and gives
// one result beat. A sample goes through accept, store lookup and
// write-back when no travel is computed; when the block has settled and a
// valid sample lies below a baseline of 2 or more, the travel quotient
// comes out of a restoring divider between lookup and write-back that
// produces one bit per cycle. The next sample is taken in the cycle after
// the result is loaded into the output register, even if that beat has
// not yet been taken; a result still held there delays only the
// following write-back. Registers may be written only while idle; the
// per-sensor store needs no clearing pass, since each entry has a valid
// bit that reset clears.
`default_nettype none

module optical_key_press_detector (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  okp_in_if.sink    in_i,
  okp_out_if.source out_o,
  okp_cfg_if.sink   cfg_i
);

  okp_pkg::ctrl_cmd_t cmd;
  okp_pkg::ctrl_sts_t sts;
  logic               in_ready;

  assign in_i.ready = in_ready;

  // sequencer
  okp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  okp_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (in_i.sample),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .cfg_i    (cfg_i),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

// ===== src/okp_checker.sv =====
// ---------------------------------------------------------------------------
// okp_checker - port-level checks of the optical key press detector
// Watches the channels and flags results that contradict the block rules.
// ---------------------------------------------------------------------------
`default_nettype none

module okp_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [okp_pkg::SENSOR_W-1:0] out_sensor_i,
  input wire logic                         out_valid_res_i,
  input wire logic [okp_pkg::TRAVEL_W-1:0] out_travel_i,
  input wire logic                         out_changed_i,
  input wire logic                         out_settled_i,
  input wire logic [okp_pkg::VCOUNT_W-1:0] out_vcount_i
);

  // a result beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sensor_i))
    else $error("result beat dropped or changed while stalled");

  // one sample in flight: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second sample accepted while one is in work");

  // travel and state changes only on settled, valid samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_changed_i || out_travel_i != '0) |->
      out_valid_res_i && out_settled_i)
    else $error("travel or change reported on an unsettled or invalid sample");

  // valid count never exceeds the samples seen in the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, out_vcount_i} <= {1'b0, out_sensor_i} + 8'd1))
    else $error("frame valid count ahead of sensor position");

endmodule

bind optical_key_press_detector okp_checker u_okp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_sensor_i    (out_o.sensor),
  .out_valid_res_i (out_o.valid_res),
  .out_travel_i    (out_o.travel),
  .out_changed_i   (out_o.changed),
  .out_settled_i   (out_o.settled),
  .out_vcount_i    (out_o.frame_valid_count)
);

`default_nettype wire

// ===== verif/okp_key_checker.sv =====
// ---------------------------------------------------------------------------
// okp_key_checker - result predictor and comparator for the key detector
// Watches the sample, result and register channels, keeps its own copy of
// the per-sensor baselines, pressed bits and frame bookkeeping, and checks
// every result beat field by field against the oldest predicted result.
// ---------------------------------------------------------------------------
`default_nettype none

module okp_key_checker
  import okp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  okp_in_if         in_mon,
  okp_out_if        out_mon,
  okp_cfg_if        cfg_mon,
  output int        pending_o,
  output int        errors_o
);

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic                valid_res;
    logic [TRAVEL_W-1:0] travel;
    logic                pressed;
    logic                changed;
    logic                frame_end;
    logic [VCOUNT_W-1:0] frame_valid_count;
    logic                settled;
  } key_result_t;

  // register copies
  logic [SENSOR_W-1:0] scan_len;
  logic [TRAVEL_W-1:0] press_thr;
  logic [TRAVEL_W-1:0] release_thr;
  logic [SETTLE_W-1:0] settle_tgt;

  // per-sensor and frame state
  logic [BASE_W-1:0]   baseline_q [MAX_SENSORS];
  logic                key_down_q [MAX_SENSORS];
  logic [SETTLE_W-1:0] settle_cnt;
  int unsigned         frame_pos;
  int unsigned         frame_valid;

  key_result_t         expected_results [$];
  int unsigned         beat_no;

  task automatic report_mismatch(string msg);
    $display("okp_key_checker: %s", msg);
    errors_o++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("beat %0d: %s is %0d, expected %0d", beat_no, name, got, want));
  endtask

  // Next result of the detector for one sample; moves the predictor state.
  function automatic key_result_t predict_key_result(logic [SAMPLE_W-1:0] smp);
    key_result_t res;
    int unsigned n, pos, s, base, trav;
    logic        ok, was_settled, last, down, next_down;
    n = scan_len;
    if (n < 1) n = 1;
    if (n > MAX_SENSORS) n = MAX_SENSORS;
    pos = (frame_pos >= MAX_SENSORS) ? MAX_SENSORS - 1 : frame_pos;
    s = smp;
    ok = (s >= 1) && (s <= SAMPLE_MAX);
    was_settled = settle_cnt >= settle_tgt;
    last = (pos + 1) >= n;
    down = key_down_q[pos];
    trav = 0;
    res.changed = 1'b0;
    if (ok) begin
      base = baseline_q[pos];
      frame_valid++;
      // baseline follows the sample upward, and always while the settle count is zero or the baseline is empty
      if (settle_cnt == 0 || base == 0 || s > base) begin
        base = s;
        baseline_q[pos] = BASE_W'(s);
      end
      if (was_settled) begin
        // Q16 share of the baseline the key has moved
        if (base >= 2 && s < base) begin
          trav = ((base - s) << 16) / base;
          if (trav > 32'hffff) trav = 32'hffff;
        end
        // hysteresis: release level while down, press level while up
        next_down = down ? (trav >= release_thr) : (trav >= press_thr);
        if (next_down != down) begin
          res.changed = 1'b1;
          down = next_down;
          key_down_q[pos] = down;
        end
      end
    end
    res.sensor            = SENSOR_W'(pos);
    res.valid_res         = ok;
    res.travel            = TRAVEL_W'(trav);
    res.pressed           = down;
    res.frame_end         = last;
    res.frame_valid_count = VCOUNT_W'(frame_valid);
    res.settled           = was_settled;
    // frame close: count a fully valid frame toward settling
    if (last) begin
      if (frame_valid == n && settle_cnt < settle_tgt) settle_cnt++;
      frame_pos = 0;
      frame_valid = 0;
    end else begin
      frame_pos = pos + 1;
    end
    return res;
  endfunction

  // monitor all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    key_result_t got, want;
    if (!rst_ni) begin
      scan_len    = RST_SENSOR_COUNT;
      press_thr   = RST_PRESS_THR;
      release_thr = RST_RELEASE_THR;
      settle_tgt  = RST_SETTLE_TGT;
      for (int i = 0; i < MAX_SENSORS; i++) begin
        baseline_q[i] = '0;
        key_down_q[i] = 1'b0;
      end
      settle_cnt  = '0;
      frame_pos   = 0;
      frame_valid = 0;
      beat_no     = 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_SENSOR_COUNT: scan_len    = cfg_mon.data[SENSOR_W-1:0];
          CFG_PRESS_THR:    press_thr   = cfg_mon.data[TRAVEL_W-1:0];
          CFG_RELEASE_THR:  release_thr = cfg_mon.data[TRAVEL_W-1:0];
          CFG_SETTLE_TGT:   settle_tgt  = cfg_mon.data[SETTLE_W-1:0];
          default: ;
        endcase
      end

      // result beats
      if (out_mon.valid && out_mon.ready) begin
        got = '{sensor: out_mon.sensor, valid_res: out_mon.valid_res,
                travel: out_mon.travel, pressed: out_mon.pressed,
                changed: out_mon.changed, frame_end: out_mon.frame_end,
                frame_valid_count: out_mon.frame_valid_count,
                settled: out_mon.settled};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("beat %0d: result for sensor %0d with none expected",
                                    beat_no, got.sensor));
        end else begin
          want = expected_results.pop_front();
          check_field("sensor", got.sensor, want.sensor);
          check_field("valid_res", got.valid_res, want.valid_res);
          check_field("travel", got.travel, want.travel);
          check_field("pressed", got.pressed, want.pressed);
          check_field("changed", got.changed, want.changed);
          check_field("frame_end", got.frame_end, want.frame_end);
          check_field("frame_valid_count", got.frame_valid_count, want.frame_valid_count);
          check_field("settled", got.settled, want.settled);
        end
        beat_no++;
      end

      // sample beats
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_key_result(in_mon.sample));

      pending_o <= expected_results.size();
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_optical_key_press_detector.sv =====
// ---------------------------------------------------------------------------
// tb_optical_key_press_detector - testbench top of the key press detector
// Drives samples and register writes with random idle gaps and output
// stalls, including one long output hold-off, while a separate checker
// predicts every result beat and counts mismatches.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_optical_key_press_detector;
  import okp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 9;

  logic        clk_i;
  logic        rst_ni;
  int          pending_beats;
  int          mismatch_count;
  bit          burst_mode;
  bit          hold_off_req;
  int unsigned cycle_count;

  okp_in_if  in_ch ();
  okp_out_if out_ch ();
  okp_cfg_if cfg_ch ();

  optical_key_press_detector uut (
    .clk_i,
    .rst_ni,
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  okp_key_checker key_check (
    .clk_i,
    .rst_ni,
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_mon   (cfg_ch),
    .pending_o (pending_beats),
    .errors_o  (mismatch_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_optical_key_press_detector: FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (int left = HOLD_CYCLES; left > 0; left--) @(posedge clk_i);
      end
      out_ch.ready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk_i);
    end
  end

  // one sample beat; valid stays up into the next beat unless a gap is rolled
  task automatic send_sample(logic [SAMPLE_W-1:0] smp);
    while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= smp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  // all four registers; unused upper data bits get noise
  task automatic configure(logic [SENSOR_W-1:0] n, logic [TRAVEL_W-1:0] p_thr,
                           logic [TRAVEL_W-1:0] r_thr, logic [SETTLE_W-1:0] tgt);
    write_reg(CFG_SENSOR_COUNT, {9'($urandom), n});
    write_reg(CFG_PRESS_THR, p_thr);
    write_reg(CFG_RELEASE_THR, r_thr);
    write_reg(CFG_SETTLE_TGT, {8'($urandom), tgt});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [TRAVEL_W-1:0] pick_threshold();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return TRAVEL_W'($urandom_range(65535));
  endfunction

  // mostly keys at rest or pressed deep, a few out-of-range readings
  function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned bad_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < bad_pct) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return '1;
        default: return SAMPLE_W'($urandom_range(65535, 4096));
      endcase
    end
    roll = $urandom_range(99);
    if (roll < 55) return SAMPLE_W'($urandom_range(4095, 3300));
    if (roll < 85) return SAMPLE_W'($urandom_range(1600, 1));
    return SAMPLE_W'($urandom_range(4095, 1));
  endfunction

  task automatic run_phase(int n_items, int unsigned bad_pct, int hold_at);
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      send_sample(pick_sample(bad_pct));
    end
    wait_drained();
  endtask

  // stimulus and verdict
  initial begin : stimulus
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_SENSOR_COUNT;
    cfg_ch.data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // two sensors, settle after one full frame; field extremes
    configure(7'd2, 16'd32768, 16'd16384, 8'd1);
    send_sample(16'd0);
    send_sample(16'd4096);
    send_sample(16'd1);
    send_sample(16'd4095);
    send_sample(16'd4095);   // baseline drifts up to the sample
    send_sample(16'd1);      // deep press
    send_sample(16'd1);
    send_sample(16'd4095);   // release
    send_sample(16'hffff);   // invalid, pressed state held
    send_sample(16'd2048);   // just under the press level
    send_sample(16'd4095);
    send_sample(16'd2047);   // just over the press level
    wait_drained();

    // threshold extremes, no settling; first touch of an empty baseline
    configure(7'd5, 16'd0, 16'hffff, 8'd0);
    send_sample(16'd1);
    send_sample(16'd2);
    send_sample(16'd3);
    wait_drained();

    // count lowered below the frame position: next sample closes the frame
    configure(7'd2, 16'hffff, 16'd0, 8'd0);
    send_sample(16'd4095);
    send_sample(16'd1);
    send_sample(16'd1);
    wait_drained();

    // count of zero acts as one; top settle target
    configure(7'd0, 16'd32768, 16'd16384, 8'd255);
    send_sample(16'd1);
    send_sample(16'd4096);
    wait_drained();

    // count above the store size; baseline of one
    configure(7'd127, 16'd32768, 16'd16384, 8'd0);
    send_sample(16'd4095);
    send_sample(16'd4095);
    send_sample(16'd3);
    send_sample(16'd4095);
    send_sample(16'd1);
    wait_drained();

    // full frames with a long output hold-off partway through
    configure(7'd72, 16'd32768, 16'd16384, 8'd2);
    run_phase(250, 1, 100);

    configure(7'd127, 16'hffff, 16'd0, 8'd3);
    run_phase(100, 2, -1);

    configure(7'd8, pick_threshold(), pick_threshold(), 8'd0);
    run_phase(150, 10, -1);

    // single-sensor frames up to the top settle target
    configure(7'd0, 16'($urandom_range(65535, 16384)), 16'($urandom_range(16383)), 8'd255);
    run_phase(320, 3, -1);

    // no idling on either side
    burst_mode = 1'b1;
    configure(7'd3, pick_threshold(), pick_threshold(), 8'($urandom_range(4)));
    run_phase(100, 5, -1);
    burst_mode = 1'b0;

    repeat (4) begin
      configure(7'($urandom_range(127)), pick_threshold(), pick_threshold(),
                8'($urandom_range(6)));
      run_phase(60, 6, -1);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_beats == 0) begin
      $display("tb_optical_key_press_detector: PASS");
    end else begin
      $display("tb_optical_key_press_detector: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/okp_pkg.sv
src/okp_if.sv
src/okp_ram.sv
src/okp_ctrl.sv
src/okp_datapath.sv
src/optical_key_press_detector.sv
src/okp_checker.sv
verif/okp_key_checker.sv
verif/tb_optical_key_press_detector.sv
